FILE: rtl/lszu_pkg.sv
package lszu_pkg;

  // default ring depths
  localparam int LONG_DEPTH_DEF  = 64;
  localparam int SHORT_DEPTH_DEF = 8;

  // field widths
  localparam int LVL_W  = 24;
  localparam int CODE_W = 16;
  localparam int GAIN_W = 24;
  localparam int OP_W   = 2;

  // item operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_ZERO   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

  // register indexes (word address on the apb port)
  localparam logic [1:0] REG_FOUR_MA = 2'd0;
  localparam logic [1:0] REG_MAX     = 2'd1;
  localparam logic [1:0] REG_GAIN    = 2'd2;

  // register reset values
  localparam logic [CODE_W-1:0] FOUR_MA_RST = 16'd6400;
  localparam logic [CODE_W-1:0] MAX_RST     = 16'd32767;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 24'd65536;

  // level saturation bounds
  localparam logic signed [LVL_W-1:0] LVL_MAX = 24'sh7fffff;
  localparam logic signed [LVL_W-1:0] LVL_MIN = 24'sh800000;

  typedef struct packed {
    logic wr;
    logic clr;
  } ring_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_LEVEL,
    ST_UPDATE
  } state_t;

endpackage

FILE: rtl/lszu_ring.sv
module lszu_ring import lszu_pkg::*; #(
  parameter int DEPTH = SHORT_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ring_ctl_t               ctl,
  input  logic [AW-1:0]           addr,
  input  logic signed [LVL_W-1:0] wdata,
  output logic signed [LVL_W-1:0] rdata
);

  logic signed [LVL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        valid;
  logic signed [LVL_W-1:0] rd;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    rd <= mem[addr];
  end

  // entries never written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[addr];
      if (ctl.clr) begin
        valid <= '0;
      end else if (ctl.wr) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? rd : '0;

endmodule

FILE: rtl/lszu_scale.sv
module lszu_scale import lszu_pkg::*; (
  input  logic                     clk,
  input  logic [CODE_W-1:0]        reading,
  input  logic [CODE_W-1:0]        four_ma_code,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [LVL_W-1:0]  offset,
  output logic signed [LVL_W-1:0]  level
);

  logic signed [CODE_W:0]          diff;
  logic signed [CODE_W+GAIN_W+1:0] prod;
  logic signed [CODE_W+GAIN_W-11:0] quo;
  logic signed [CODE_W+GAIN_W-10:0] lvl;

  assign diff = $signed({1'b0, reading}) - $signed({1'b0, four_ma_code});

  always_ff @(posedge clk) begin
    prod <= diff * $signed({1'b0, gain});
  end

  // floor division by 4096 is the upper bits of the product
  assign quo = prod[CODE_W+GAIN_W+1:12];
  assign lvl = {quo[CODE_W+GAIN_W-11], quo}
             - {{(CODE_W+GAIN_W-9-LVL_W){offset[LVL_W-1]}}, offset};

  always_ff @(posedge clk) begin
    if (lvl > $signed({{(CODE_W+GAIN_W-9-LVL_W){1'b0}}, LVL_MAX})) begin
      level <= LVL_MAX;
    end else if (lvl < $signed({{(CODE_W+GAIN_W-9-LVL_W){1'b1}}, LVL_MIN})) begin
      level <= LVL_MIN;
    end else begin
      level <= lvl[LVL_W-1:0];
    end
  end

endmodule

FILE: rtl/level_sensor_averaging_with_zeroing_unit.sv
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-------------------------------------------
// s_*      | in        | s_tvalid / s_tready   | tuser: op; tdata: reading, offset_value
// m_*      | out       | m_tvalid / m_tready   | tdata: accepted, level, long_average,
//          |           |                       |        short_average, zero_updated, zero_offset
// apb      | in        | psel, penable, pready | four_ma_code, max_code, gain_mm_per_code
//
// an item steps through accept, product, level and saturation, then ring read-modify-write
// no new item is taken until the previous one has finished its ring read-modify-write
// ring clears use per-entry valid bits, so no clearing pass after reset
// synchronous active-high reset; config registers return to their defaults
// a result waits in the output register while the next item is taken and processed;
// that item's result then waits for the output register to free, holding off new items
module level_sensor_averaging_with_zeroing_unit import lszu_pkg::*; #(
  parameter int LONG_DEPTH  = LONG_DEPTH_DEF,
  parameter int SHORT_DEPTH = SHORT_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input item stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // [15:0] reading, [39:16] offset_value
  input  logic [1:0]   s_tuser,   // [1:0] op
  // result item stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [0] accepted, [24:1] level, [48:25] long_average,
                                  // [72:49] short_average, [73] zero_updated,
                                  // [97:74] zero_offset, [103:98] zero
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int LAW    = $clog2(LONG_DEPTH);
  localparam int SAW    = $clog2(SHORT_DEPTH);
  localparam int FW     = $clog2(LONG_DEPTH + 1);
  localparam int LSUM_W = LVL_W + LAW;
  localparam int SSUM_W = LVL_W + SAW;

  // configuration registers
  logic [CODE_W-1:0] four_ma_code;
  logic [CODE_W-1:0] max_code;
  logic [GAIN_W-1:0] gain_mm_per_code;
  logic              cfg_wr;

  // item registers
  logic [OP_W-1:0]         op_q;
  logic [CODE_W-1:0]       reading_q;
  logic signed [LVL_W-1:0] offv_q;

  // block state
  state_t                   state, state_next;
  logic signed [LVL_W-1:0]  offset;
  logic signed [LVL_W-1:0]  last_level;
  logic signed [LSUM_W-1:0] long_sum;
  logic signed [SSUM_W-1:0] short_sum;
  logic [LAW-1:0]           long_slot;
  logic [SAW-1:0]           short_slot;
  logic [FW-1:0]            fill;
  logic                     zero_pend;
  logic                     acc_q;
  logic                     zupd_q;
  logic                     res_pend;

  // datapath
  logic signed [LVL_W-1:0]  level_val;
  logic signed [LVL_W-1:0]  long_old, short_old;
  logic signed [LVL_W:0]    long_delta, short_delta;
  logic signed [LSUM_W-1:0] long_sum_upd;
  logic signed [SSUM_W-1:0] short_sum_upd;
  logic signed [LSUM_W-1:0] long_shift, long_shift_upd;
  logic signed [SSUM_W-1:0] short_shift;
  logic signed [LVL_W-1:0]  long_avg, long_avg_upd, short_avg;
  logic                     acc;
  logic                     fill_full;
  logic                     zero_done;
  logic                     upd;
  logic                     load;
  ring_ctl_t                long_ctl, short_ctl;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_ma_code     <= FOUR_MA_RST;
      max_code         <= MAX_RST;
      gain_mm_per_code <= GAIN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FOUR_MA: four_ma_code     <= pwdata[CODE_W-1:0];
        REG_MAX:     max_code         <= pwdata[CODE_W-1:0];
        REG_GAIN:    gain_mm_per_code <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FOUR_MA: prdata = {16'd0, four_ma_code};
      REG_MAX:     prdata = {16'd0, max_code};
      REG_GAIN:    prdata = {8'd0, gain_mm_per_code};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- units
  lszu_scale u_scale (
    .clk          (clk),
    .reading      (reading_q),
    .four_ma_code (four_ma_code),
    .gain         (gain_mm_per_code),
    .offset       (offset),
    .level        (level_val)
  );

  lszu_ring #(.DEPTH(LONG_DEPTH)) u_long_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (long_ctl),
    .addr  (long_slot),
    .wdata (level_val),
    .rdata (long_old)
  );

  lszu_ring #(.DEPTH(SHORT_DEPTH)) u_short_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (short_ctl),
    .addr  (short_slot),
    .wdata (level_val),
    .rdata (short_old)
  );

  // ---------------------------------------------------------------- update logic
  assign upd       = (state == ST_UPDATE);
  assign acc       = (op_q == OP_SAMPLE) && (reading_q > 16'd1) && (reading_q <= max_code);
  assign fill_full = (fill == FW'(LONG_DEPTH));
  assign zero_done = (op_q == OP_SAMPLE) && fill_full && zero_pend;

  // ring slot swap: new level in, old level out of the running sums
  assign long_delta    = {level_val[LVL_W-1], level_val} - {long_old[LVL_W-1], long_old};
  assign short_delta   = {level_val[LVL_W-1], level_val} - {short_old[LVL_W-1], short_old};
  assign long_sum_upd  = long_sum + {{(LSUM_W-LVL_W-1){long_delta[LVL_W]}}, long_delta};
  assign short_sum_upd = short_sum + {{(SSUM_W-LVL_W-1){short_delta[LVL_W]}}, short_delta};

  // averages are arithmetic shifts, rounding toward minus infinity
  assign long_shift     = long_sum >>> LAW;
  assign long_shift_upd = long_sum_upd >>> LAW;
  assign short_shift    = short_sum >>> SAW;
  assign long_avg       = long_shift[LVL_W-1:0];
  assign long_avg_upd   = long_shift_upd[LVL_W-1:0];
  assign short_avg      = short_shift[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      offset     <= '0;
      last_level <= '0;
      long_sum   <= '0;
      short_sum  <= '0;
      long_slot  <= '0;
      short_slot <= '0;
      fill       <= FW'(1);
      zero_pend  <= 1'b0;
      acc_q      <= 1'b0;
      zupd_q     <= 1'b0;
    end else if (upd) begin
      acc_q  <= acc;
      zupd_q <= zero_done;
      case (op_q)
        OP_SAMPLE: begin
          if (acc) begin
            last_level <= level_val;
            long_sum   <= long_sum_upd;
            short_sum  <= short_sum_upd;
            long_slot  <= (long_slot == LAW'(LONG_DEPTH - 1)) ? '0 : long_slot + 1'b1;
            short_slot <= (short_slot == SAW'(SHORT_DEPTH - 1)) ? '0 : short_slot + 1'b1;
          end
          if (fill_full) begin
            fill <= '0;
            if (zero_pend) begin
              // long average becomes the zero, both rings start over
              offset     <= acc ? long_avg_upd : long_avg;
              long_sum   <= '0;
              short_sum  <= '0;
              long_slot  <= '0;
              short_slot <= '0;
              zero_pend  <= 1'b0;
            end
          end else if (fill != '0) begin
            fill <= fill + 1'b1;
          end
        end
        OP_ZERO: begin
          offset    <= '0;
          long_sum  <= '0;
          long_slot <= '0;
          zero_pend <= 1'b1;
          fill      <= FW'(1);
        end
        OP_LOAD: begin
          offset <= offv_q;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid && s_tready) state_next = ST_MUL;
      ST_MUL:    state_next = ST_LEVEL;
      ST_LEVEL:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    load          = res_pend && (!m_tvalid || m_tready);
    s_tready      = (state == ST_IDLE) && (!res_pend || load);
    long_ctl.wr   = upd && acc;
    long_ctl.clr  = upd && (zero_done || (op_q == OP_ZERO));
    short_ctl.wr  = upd && acc;
    short_ctl.clr = upd && zero_done;
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q      <= s_tuser;
      reading_q <= s_tdata[15:0];
      offv_q    <= s_tdata[39:16];
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (upd) begin
        res_pend <= 1'b1;
      end else if (load) begin
        res_pend <= 1'b0;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'd0, offset, zupd_q, short_avg, long_avg, last_level, acc_q};
    end
  end

  // ---------------------------------------------------------------- assertions
  a_item_spacing: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("item accepted before the previous one finished");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(LONG_DEPTH))
    else $error("startup counter past the long depth");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    upd && zero_done |=> !zero_pend && long_sum == '0 && short_sum == '0
                         && long_slot == '0 && short_slot == '0)
    else $error("zeroing did not clear the rings");

  a_zero_start: assert property (@(posedge clk) disable iff (rst)
    upd && (op_q == OP_ZERO) |=> zero_pend && fill == FW'(1) && offset == '0)
    else $error("zero command did not restart the count");

endmodule
